### rtl/core/bit_vector_store_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the bit vector store
// Shared concurrent checks, each used on a line of its own.
// ----------------------------------------------------------------------------
`ifndef BIT_VECTOR_STORE_TOP_DEFINES_SVH
`define BIT_VECTOR_STORE_TOP_DEFINES_SVH

// plain implication check under reset
`define BVS_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication check under reset
`define BVS_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/core/bvs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvs_pkg
// Shared constants and types of the bit vector store.
// ----------------------------------------------------------------------------
package bvs_pkg;
	localparam int MAX_BITS_DEF  = 1024;
	localparam int WORD_BITS_DEF = 32;
	localparam logic [31:0] HASH_MUL = 32'h1f1f1f1f;

	localparam logic [2:0] FN_GET    = 3'd0;
	localparam logic [2:0] FN_SET    = 3'd1;
	localparam logic [2:0] FN_INSERT = 3'd2;
	localparam logic [2:0] FN_RANGE  = 3'd3;
	localparam logic [2:0] FN_ALL    = 3'd4;
	localparam logic [2:0] FN_RESIZE = 3'd5;
	localparam logic [2:0] FN_HASH   = 3'd6;

	// memory access request from the sequencer
	typedef struct packed {
		logic        rd;
		logic        wr;
		logic [15:0] addr;
	} mem_req_t;
endpackage

### rtl/core/bvs_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bvs_mem
// Word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bvs_mem import bvs_pkg::*; #(
	parameter int WORDS = 32,
	parameter int WB    = 32,
	parameter int AW    = 5
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [WB-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [WB-1:0] rdata
);
	logic [WB-1:0] mem [WORDS];

	// synchronous write and read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/bit_vector_store_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_vector_store_top
// Variable-length bit vector held in a word memory, one request at a time.
// ----------------------------------------------------------------------------
// After reset a clearing pass over all WORDS words (32 by default) zeroes the
// word memory; no request is taken meanwhile. A request then runs through a
// sequencer that reads, modifies and writes back one word at a time over the
// single memory port pair: get and set bit touch one word, range, set all and
// resize visit the words they touch, insert walks from the index word up to
// the top word, carrying each word's top bit into the next, and the hash reads
// each word in use and does one multiply a byte. The result is held in an
// output register until taken, and the next request is accepted while it
// waits.
// ----------------------------------------------------------------------------
module bit_vector_store_top import bvs_pkg::*; #(
	parameter int MAX_BITS  = MAX_BITS_DEF,
	parameter int WORD_BITS = WORD_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  logic [10:0] index_a,
	input  logic [10:0] index_b,
	input  logic        bit_value,
	input  logic [10:0] new_size,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        bit_out,
	output logic        ok,
	output logic [31:0] hash_out,
	output logic [10:0] size_out
);
`include "bit_vector_store_top_defines.svh"

	localparam int WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int BW    = $clog2(WORD_BITS);
	localparam int CW    = $clog2(MAX_BITS + 1);
	localparam int NB    = WORD_BITS / 8;
	localparam int NBW   = (NB > 1) ? $clog2(NB) : 1;

	localparam logic [3:0] ST_CLR   = 4'd0;
	localparam logic [3:0] ST_IDLE  = 4'd1;
	localparam logic [3:0] ST_RD    = 4'd2;
	localparam logic [3:0] ST_MOD   = 4'd3;
	localparam logic [3:0] ST_DONE  = 4'd4;
	localparam logic [3:0] ST_HRD   = 4'd5;
	localparam logic [3:0] ST_HBYTE = 4'd6;
	localparam logic [3:0] ST_HMUL  = 4'd7;
	localparam logic [3:0] ST_HNXT  = 4'd8;

	logic [3:0]           state_q;
	logic [2:0]           func_q;
	logic [CW-1:0]        lo_q, hi_q;
	logic                 val_q;
	logic [CW-1:0]        count_q;
	logic [AW-1:0]        wa_q;
	logic [AW-1:0]        wend_q;
	logic                 carry_q;
	logic                 ok_q;
	logic                 bit_q;
	logic [31:0]          hash_q;
	logic [31:0]          prod_q;
	logic [CW-1:0]        nbyte_q;
	logic [CW-1:0]        byte_q;
	logic [7:0]           byte_val_q;
	logic [WORD_BITS-1:0] word_q;
	logic                 res_full_q;
	logic                 res_load;
	logic [31:0]          hash_mul;

	logic                 mem_we;
	logic [AW-1:0]        mem_waddr, mem_raddr;
	logic [WORD_BITS-1:0] mem_wdata, mem_rdata;

	bvs_mem #(.WORDS(WORDS), .WB(WORD_BITS), .AW(AW)) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// word that holds a bit index
	function automatic logic [AW-1:0] word_of(input logic [CW-1:0] b);
		logic [CW-1:0] w;
		w = b >> BW;
		return w[AW-1:0];
	endfunction

	// per-bit mask of [lo,hi] inside the current word wa_q
	logic [WORD_BITS-1:0] rng_mask;
	always_comb begin
		logic [CW:0] pos;
		for (int j = 0; j < WORD_BITS; j++) begin
			pos = (CW+1)'({wa_q, BW'(j)});
			rng_mask[j] = ({1'b0, lo_q} <= pos) && (pos <= {1'b0, hi_q});
		end
	end

	// insert: shift bits at and above the index up by one, carry in from below
	logic [WORD_BITS-1:0] ins_word;
	logic [BW-1:0]        ia_bit;
	assign ia_bit = lo_q[BW-1:0];
	always_comb begin
		ins_word = mem_rdata;
		if (wa_q == word_of(lo_q)) begin
			if (ia_bit == '0) begin
				ins_word[0] = val_q;
			end
			for (int j = 1; j < WORD_BITS; j++) begin
				if (BW'(j) > ia_bit) begin
					ins_word[j] = mem_rdata[j-1];
				end else if (BW'(j) == ia_bit) begin
					ins_word[j] = val_q;
				end
			end
		end else begin
			ins_word = {mem_rdata[WORD_BITS-2:0], carry_q};
		end
	end

	// new word contents for the current request
	logic [WORD_BITS-1:0] mod_word;
	always_comb begin
		case (func_q)
			FN_SET, FN_RANGE, FN_ALL:
				mod_word = val_q ? (mem_rdata | rng_mask) : (mem_rdata & ~rng_mask);
			FN_RESIZE: mod_word = mem_rdata & ~rng_mask;
			FN_INSERT: mod_word = ins_word;
			default:   mod_word = mem_rdata;
		endcase
	end

	// request checks at accept time
	logic          acc;
	logic          chk_ok;
	logic [CW-1:0] ia_c, ib_c, ns_c;
	logic          ia_big, ib_big, ns_big;
	assign ia_big = (11'(index_a) >> CW) != '0;
	assign ib_big = (11'(index_b) >> CW) != '0;
	assign ns_big = (11'(new_size) >> CW) != '0;
	assign ia_c   = CW'(index_a);
	assign ib_c   = CW'(index_b);
	assign ns_c   = CW'(new_size);
	always_comb begin
		case (func)
			FN_GET, FN_SET: chk_ok = !ia_big && ia_c < count_q;
			FN_INSERT: chk_ok = !ia_big && ia_c <= count_q
				&& {1'b0, count_q} < (CW+1)'(MAX_BITS);
			FN_RANGE:  chk_ok = !ia_big && !ib_big && ia_c < count_q && ib_c < count_q;
			FN_ALL, FN_HASH: chk_ok = 1'b1;
			FN_RESIZE: chk_ok = !ns_big && {1'b0, ns_c} <= (CW+1)'(MAX_BITS);
			default:   chk_ok = 1'b0;
		endcase
	end

	assign in_stall = !(state_q == ST_IDLE);
	assign acc      = in_valid && !in_stall;
	assign res_load = (state_q == ST_DONE) && (!res_full_q || !out_stall);
	assign hash_mul = hash_q * HASH_MUL;

	// memory port drive
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = wa_q;
		mem_wdata = mod_word;
		mem_raddr = wa_q;
		if (state_q == ST_CLR) begin
			mem_we    = 1'b1;
			mem_wdata = '0;
		end else if (state_q == ST_MOD && func_q != FN_GET) begin
			mem_we = 1'b1;
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLR;
			wa_q       <= '0;
			count_q    <= '0;
			res_full_q <= 1'b0;
		end else begin
			res_full_q <= res_load || (res_full_q && out_stall);
			case (state_q)
				ST_CLR: begin
					wa_q <= wa_q + AW'(1);
					if (wa_q == AW'(WORDS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (acc) begin
						func_q <= func;
						val_q  <= bit_value;
						ok_q   <= chk_ok;
						bit_q  <= 1'b0;
						hash_q <= 32'(count_q);
						byte_q <= '0;
						nbyte_q <= CW'(({1'b0, count_q} + (CW+1)'(7)) >> 3);
						state_q <= ST_DONE;
						if (chk_ok) begin
							case (func)
								FN_GET, FN_SET: begin
									lo_q <= ia_c; hi_q <= ia_c;
									wa_q <= word_of(ia_c); wend_q <= word_of(ia_c);
									state_q <= ST_RD;
								end
								FN_INSERT: begin
									lo_q <= ia_c; hi_q <= count_q;
									wa_q <= word_of(ia_c); wend_q <= word_of(count_q);
									state_q <= ST_RD;
									count_q <= count_q + CW'(1);
								end
								FN_RANGE: begin
									lo_q <= (ia_c < ib_c) ? ia_c : ib_c;
									hi_q <= (ia_c < ib_c) ? ib_c : ia_c;
									wa_q <= word_of((ia_c < ib_c) ? ia_c : ib_c);
									wend_q <= word_of((ia_c < ib_c) ? ib_c : ia_c);
									state_q <= ST_RD;
								end
								FN_ALL: begin
									if (count_q != '0) begin
										lo_q <= '0; hi_q <= count_q - CW'(1);
										wa_q <= '0; wend_q <= word_of(count_q - CW'(1));
										state_q <= ST_RD;
									end
								end
								FN_RESIZE: begin
									count_q <= ns_c;
									if (ns_c < count_q) begin
										lo_q <= ns_c; hi_q <= count_q - CW'(1);
										wa_q <= word_of(ns_c);
										wend_q <= word_of(count_q - CW'(1));
										val_q <= 1'b0;
										state_q <= ST_RD;
									end
								end
								FN_HASH: begin
									wa_q <= '0;
									if (count_q != '0) begin
										state_q <= ST_HRD;
									end
								end
								default: state_q <= ST_DONE;
							endcase
						end
					end
				end
				ST_RD: begin
					// read issued, word is on the read port in ST_MOD
					state_q <= ST_MOD;
				end
				ST_MOD: begin
					if (func_q == FN_GET) begin
						bit_q <= mem_rdata[lo_q[BW-1:0]];
					end
					if (wa_q == wend_q) begin
						state_q <= ST_DONE;
					end else begin
						state_q <= ST_RD;
						wa_q    <= wa_q + AW'(1);
					end
				end
				ST_HRD: state_q <= ST_HBYTE;
				ST_HBYTE: begin
					word_q     <= mem_rdata;
					byte_val_q <= mem_rdata[byte_q[NBW-1:0]*8 +: 8];
					prod_q     <= hash_mul;
					state_q    <= ST_HMUL;
				end
				ST_HMUL: begin
					hash_q <= prod_q + 32'(byte_val_q);
					byte_q <= byte_q + CW'(1);
					if (byte_q + CW'(1) == nbyte_q) begin
						state_q <= ST_DONE;
					end else if (byte_q[NBW-1:0] == NBW'(NB - 1)) begin
						wa_q    <= wa_q + AW'(1);
						state_q <= ST_HRD;
					end else begin
						state_q <= ST_HNXT;
					end
				end
				ST_HNXT: begin
					byte_val_q <= word_q[byte_q[NBW-1:0]*8 +: 8];
					prod_q     <= hash_mul;
					state_q    <= ST_HMUL;
				end
				ST_DONE: begin
					if (res_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// insert carry: old top bit of the word just rewritten, shifted into the next
	always_ff @(posedge clk) begin
		if (state_q == ST_MOD && func_q == FN_INSERT) begin
			carry_q <= mem_rdata[WORD_BITS-1];
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (res_load) begin
			bit_out  <= bit_q;
			ok       <= ok_q;
			hash_out <= (func_q == FN_HASH) ? hash_q : 32'd0;
			size_out <= 11'(count_q);
		end
	end
	assign out_valid = res_full_q;

	`BVS_ASSERT_IMP(a_no_acc_busy, clk, arst_n, state_q != ST_IDLE, !acc, "accept while busy")
	`BVS_ASSERT_IMP(a_cnt_max, clk, arst_n, 1'b1, {1'b0, count_q} <= (CW+1)'(MAX_BITS), "count over max")
	`BVS_ASSERT_NXT(a_hold, clk, arst_n, out_valid && out_stall, out_valid, "result dropped")
endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives requests into the bit vector store and checks every result beat
// against a behavioural copy of the vector kept alongside the block.
// ----------------------------------------------------------------------------
module testbench;
	import bvs_pkg::*;

	localparam int VEC_MAX   = 1024;
	localparam int WATCHDOG  = 20000;
	localparam int LONG_HOLD = 300;
	localparam logic [2:0] FN_BAD = 3'd7;

	typedef struct packed {
		logic        bit_out;
		logic        ok;
		logic [31:0] hash_out;
		logic [10:0] size_out;
	} vec_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [2:0]  func = '0;
	logic [10:0] index_a = '0;
	logic [10:0] index_b = '0;
	logic        bit_value = 1'b0;
	logic [10:0] new_size = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        bit_out;
	logic        ok;
	logic [31:0] hash_out;
	logic [10:0] size_out;

	// model of the vector contents
	logic [VEC_MAX-1:0] vec_bits = '0;
	int unsigned        vec_len = 0;

	vec_result_t result_queue[$];
	int  mismatches = 0;
	int  idle_cycles = 0;
	bit  send_idle_en = 1'b1;
	bit  recv_idle_en = 1'b1;
	bit  hold_req = 1'b0;
	int  long_cnt = 0;
	int  hold_off = 0;

	bit_vector_store_top dut (.*);

	// clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// work out the result of one request and update the model
	function automatic vec_result_t predict_request(logic [2:0] fn, int unsigned ia,
		int unsigned ib, logic v, int unsigned ns);
		vec_result_t r;
		int unsigned lo, hi;
		logic [7:0] byte_val;
		r = '0;
		case (fn)
			FN_GET: if (ia < vec_len) begin
				r.bit_out = vec_bits[ia];
				r.ok = 1'b1;
			end
			FN_SET: if (ia < vec_len) begin
				vec_bits[ia] = v;
				r.ok = 1'b1;
			end
			FN_INSERT: if (ia <= vec_len && vec_len < VEC_MAX) begin
				for (int i = vec_len; i > ia; i--) vec_bits[i] = vec_bits[i-1];
				vec_bits[ia] = v;
				vec_len++;
				r.ok = 1'b1;
			end
			FN_RANGE: if (ia < vec_len && ib < vec_len) begin
				lo = ia < ib ? ia : ib;
				hi = ia < ib ? ib : ia;
				for (int i = lo; i <= hi; i++) vec_bits[i] = v;
				r.ok = 1'b1;
			end
			FN_ALL: begin
				for (int i = 0; i < vec_len; i++) vec_bits[i] = v;
				r.ok = 1'b1;
			end
			FN_RESIZE: if (ns <= VEC_MAX) begin
				for (int i = ns; i < vec_len; i++) vec_bits[i] = 1'b0;
				vec_len = ns;
				r.ok = 1'b1;
			end
			FN_HASH: begin
				r.hash_out = vec_len;
				for (int k = 0; k < (vec_len + 7) / 8; k++) begin
					byte_val = vec_bits[k*8 +: 8];
					r.hash_out = r.hash_out * HASH_MUL + byte_val;
				end
				r.ok = 1'b1;
			end
			default: ;
		endcase
		r.size_out = 11'(vec_len);
		return r;
	endfunction

	// send one request beat, now and then with a random gap before it
	task automatic send_request(logic [2:0] fn, int unsigned ia, int unsigned ib,
		int unsigned v, int unsigned ns);
		if (send_idle_en && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		func <= fn;
		index_a <= 11'(ia);
		index_b <= 11'(ib);
		bit_value <= 1'(v);
		new_size <= 11'(ns);
		in_valid <= 1'b1;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		result_queue.push_back(predict_request(fn, ia, ib, 1'(v), ns));
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		@(posedge clk);
		while (result_queue.size() != 0) @(posedge clk);
	endtask

	// directed: extremes of every operation and the failure cases
	task automatic test_directed();
		send_request(FN_HASH, 0, 0, 0, 0);
		send_request(FN_GET, 0, 0, 0, 0);
		send_request(FN_SET, 0, 0, 1, 0);
		send_request(FN_RANGE, 0, 0, 1, 0);
		send_request(FN_ALL, 0, 0, 1, 0);
		send_request(FN_INSERT, 1, 0, 1, 0);
		send_request(FN_INSERT, 0, 0, 1, 0);
		send_request(FN_INSERT, 1, 0, 0, 0);
		send_request(FN_INSERT, 0, 0, 0, 0);
		send_request(FN_GET, 1, 0, 0, 0);
		send_request(FN_RESIZE, 0, 0, 0, 1025);
		send_request(FN_RESIZE, 0, 0, 0, 2047);
		send_request(FN_RESIZE, 0, 0, 0, 1024);
		send_request(FN_INSERT, 5, 0, 1, 0);
		send_request(FN_RANGE, 1023, 0, 1, 0);
		send_request(FN_RANGE, 1024, 3, 1, 0);
		send_request(FN_HASH, 0, 0, 0, 0);
		send_request(FN_RESIZE, 0, 0, 0, 1024);
		send_request(FN_GET, 2047, 2047, 1, 2047);
		send_request(FN_ALL, 0, 0, 0, 0);
		send_request(FN_RESIZE, 0, 0, 0, 13);
		send_request(FN_BAD, 3, 3, 1, 3);
		send_request(FN_HASH, 0, 0, 0, 0);
		send_request(FN_RESIZE, 0, 0, 0, 0);
		drain_results();
	endtask

	// random requests, indexes mostly inside the current length
	task automatic test_random(int count);
		logic [2:0] fn;
		int unsigned ia, ib, ns;
		for (int n = 0; n < count; n++) begin
			fn = $urandom_range(0, 15) == 0 ? 3'($urandom_range(0, 7))
				: 3'($urandom_range(0, 6));
			ia = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
				: $urandom_range(0, vec_len);
			ib = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047)
				: $urandom_range(0, vec_len);
			if ($urandom_range(0, 9) == 0) ns = $urandom_range(0, 2047);
			else if ($urandom_range(0, 9) == 0) ns = VEC_MAX;
			else ns = $urandom_range(0, 200);
			if (fn == FN_RESIZE && $urandom_range(0, 3) != 0 && ns > 300)
				ns = $urandom_range(0, 300);
			send_request(fn, ia, ib, $urandom_range(0, 1), ns);
		end
	endtask

	// receiver holds off while the sender keeps offering beats
	task automatic test_back_pressure();
		hold_req = 1'b1;
		test_random(20);
		hold_req = 1'b0;
		drain_results();
	endtask

	// no idling on either side
	task automatic test_streaming();
		send_idle_en = 1'b0;
		recv_idle_en = 1'b0;
		test_random(150);
		drain_results();
	endtask

	// result checker
	always @(posedge clk) begin
		vec_result_t got, want;
		if (out_valid && !out_stall) begin
			got = '{bit_out, ok, hash_out, size_out};
			if (result_queue.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result beat %p", got);
			end else begin
				want = result_queue.pop_front();
				if (got !== want) begin
					mismatches++;
					if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
				end
			end
		end
	end

	// receiver stall: one long hold on request, otherwise random bursts
	always @(posedge clk) begin
		if (hold_req && long_cnt < LONG_HOLD) begin
			long_cnt  <= long_cnt + 1;
			out_stall <= 1'b1;
		end else begin
			if (!hold_req) long_cnt <= 0;
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_stall <= 1'b1;
			end else if (recv_idle_en && $urandom_range(0, 5) == 0) begin
				hold_off <= $urandom_range(0, 16);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// watchdog on cycles without any beat
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_random(400);
		drain_results();
		test_back_pressure();
		test_random(360);
		test_streaming();
		repeat (200) @(posedge clk);
		if (mismatches == 0 && result_queue.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end
endmodule
